// ----- design/fpa_pkg.sv -----
// shared types and constants for the q24.8 fixed-point alu
// no dependencies
`timescale 1ns / 1ps

package fpa_pkg;

   localparam int unsigned FRAC_BITS_DEF = 8;

   typedef enum logic [3:0] {
      ACT_ADD      = 4'd0,
      ACT_SUB      = 4'd1,
      ACT_MUL      = 4'd2,
      ACT_DIV      = 4'd3,
      ACT_EQ       = 4'd4,
      ACT_NE       = 4'd5,
      ACT_LT       = 4'd6,
      ACT_GT       = 4'd7,
      ACT_LE       = 4'd8,
      ACT_GE       = 4'd9,
      ACT_MIN      = 4'd10,
      ACT_MAX      = 4'd11,
      ACT_INC      = 4'd12,
      ACT_DEC      = 4'd13,
      ACT_FROM_INT = 4'd14,
      ACT_TO_INT   = 4'd15
   } action_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_OVF  = 2'd1,
      ST_DIV0 = 2'd2
   } status_type;

   localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] SAT_MIN = 32'h8000_0000;

   // payload that rides alongside the divider stages
   typedef struct packed {
      action_type  action;
      logic [31:0] res;
      logic        cmp;
      status_type  status;
      logic        neg;
      logic        dz;
      logic [63:0] prod;
   } carry_type;

endpackage

// ----- design/fixed_point_alu_q24_8.sv -----
// stages: input register, operand prep with the 32x32 multiply, one stage per
// quotient bit of the pipelined divider (FRAC_BITS + 33), output register.
// throughput: one transfer per cycle while the output is not stalled; each
// stage moves when it is empty or its successor moves, so bubbles close up
// under output back-pressure.
// reset clears all stage valid bits; payload registers are not reset.
`timescale 1ns / 1ps

module fixed_point_alu_q24_8
   import fpa_pkg::*;
#(
   parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // operand_a [31:0], operand_b [63:32]
   input  logic [3:0]  req_tuser,  // action [3:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata   // result_value [31:0], compare_true [32],
                                   // status [34:33], zero [39:35]
);

   // numerator width: (|a| << frac+1) + |b| stays below 2^(33+frac)
   localparam int unsigned NW = 33 + FRAC_BITS;
   // stage 0 input, 1 prep, 2..NW+1 divider, NW+2 output
   localparam int unsigned NS = NW + 3;

   logic [NS-1:0] v_ff, v_in;
   logic [NS-1:0] en;

   // enable chain: a stage loads when empty or when its successor loads
   always_comb begin
      en[NS-1] = !v_ff[NS-1] || rsp_tready;
      for (int i = NS - 2; i >= 0; i--) begin
         en[i] = !v_ff[i] || en[i+1];
      end
   end

   assign req_tready = en[0];

   always_comb begin
      v_in[0] = en[0] ? req_tvalid : v_ff[0];
      for (int i = 1; i < NS; i++) begin
         v_in[i] = en[i] ? v_ff[i-1] : v_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   // ---------------------------------------------------------------- stage 0
   action_type         act_ff;
   logic signed [31:0] a_ff;
   logic signed [31:0] b_ff;

   always_ff @(posedge clock) begin
      if (en[0] && req_tvalid) begin
         act_ff <= action_type'(req_tuser);
         a_ff   <= req_tdata[31:0];
         b_ff   <= req_tdata[63:32];
      end
   end

   // ---------------------------------------------------------------- stage 1
   // simple actions finish here; mul and div get their operands ready
   carry_type     prep_in;
   logic [NW-1:0] num_in;
   logic [32:0]   dvs_in;

   logic [31:0]        mag_a, mag_b;
   logic signed [32:0] sum, dif, incv, decv;
   logic signed [63:0] shl;
   logic               lt, eq;

   always_comb begin
      mag_a = a_ff[31] ? 32'(-a_ff) : a_ff;
      mag_b = b_ff[31] ? 32'(-b_ff) : b_ff;
      sum   = 33'(a_ff) + 33'(b_ff);
      dif   = 33'(a_ff) - 33'(b_ff);
      incv  = 33'(a_ff) + 33'sd1;
      decv  = 33'(a_ff) - 33'sd1;
      shl   = 64'(a_ff) <<< FRAC_BITS;
      lt    = (a_ff < b_ff);
      eq    = (a_ff == b_ff);

      prep_in.action = act_ff;
      prep_in.res    = '0;
      prep_in.cmp    = 1'b0;
      prep_in.status = ST_OK;
      prep_in.neg    = a_ff[31] ^ b_ff[31];
      prep_in.dz     = (b_ff == '0);
      prep_in.prod   = 64'(mag_a) * 64'(mag_b);

      num_in = (NW'(mag_a) << (FRAC_BITS + 1)) + NW'(mag_b);
      dvs_in = {mag_b, 1'b0};

      case (act_ff)
         ACT_ADD: begin
            prep_in.res = sum[31:0];
            if (sum[32] != sum[31]) begin
               prep_in.res    = sum[32] ? SAT_MIN : SAT_MAX;
               prep_in.status = ST_OVF;
            end
         end
         ACT_SUB: begin
            prep_in.res = dif[31:0];
            if (dif[32] != dif[31]) begin
               prep_in.res    = dif[32] ? SAT_MIN : SAT_MAX;
               prep_in.status = ST_OVF;
            end
         end
         ACT_INC: begin
            prep_in.res = incv[31:0];
            if (incv[32] != incv[31]) begin
               prep_in.res    = SAT_MAX;
               prep_in.status = ST_OVF;
            end
         end
         ACT_DEC: begin
            prep_in.res = decv[31:0];
            if (decv[32] != decv[31]) begin
               prep_in.res    = SAT_MIN;
               prep_in.status = ST_OVF;
            end
         end
         ACT_FROM_INT: begin
            prep_in.res = shl[31:0];
            if ((shl[63:31] != '0) && (shl[63:31] != '1)) begin
               prep_in.res    = a_ff[31] ? SAT_MIN : SAT_MAX;
               prep_in.status = ST_OVF;
            end
         end
         ACT_TO_INT: prep_in.res = 32'(a_ff >>> FRAC_BITS);
         ACT_EQ:     prep_in.cmp = eq;
         ACT_NE:     prep_in.cmp = !eq;
         ACT_LT:     prep_in.cmp = lt;
         ACT_GT:     prep_in.cmp = !lt && !eq;
         ACT_LE:     prep_in.cmp = lt || eq;
         ACT_GE:     prep_in.cmp = !lt;
         ACT_MIN:    prep_in.res = (lt || eq) ? a_ff : b_ff;
         ACT_MAX:    prep_in.res = (!lt) ? a_ff : b_ff;
         default:    prep_in.res = '0;   // mul and div finish at the end
      endcase
   end

   carry_type     carry_ff [1:NW+1];
   logic [NW-1:0] num_ff;
   logic [32:0]   dvs_ff;

   always_ff @(posedge clock) begin
      if (en[1]) begin
         carry_ff[1] <= prep_in;
         num_ff      <= num_in;
         dvs_ff      <= dvs_in;
      end
   end

   // ------------------------------------------------------- divider stages
   logic [32:0]   rem_w [0:NW];
   logic [NW-1:0] quo_w [0:NW];
   logic [32:0]   d_w   [0:NW];

   assign rem_w[0] = '0;
   assign quo_w[0] = num_ff;
   assign d_w[0]   = dvs_ff;

   for (genvar j = 0; j < NW; j++) begin : g_div
      fpa_div_stage #(.NW(NW)) u_step (
         .clock  (clock),
         .en     (en[j+2]),
         .rem_i  (rem_w[j]),
         .quo_i  (quo_w[j]),
         .d_i    (d_w[j]),
         .rem_ff (rem_w[j+1]),
         .quo_ff (quo_w[j+1]),
         .d_ff   (d_w[j+1])
      );

      always_ff @(posedge clock) begin
         if (en[j+2]) begin
            carry_ff[j+2] <= carry_ff[j+1];
         end
      end
   end

   // ---------------------------------------------------------- output stage
   carry_type   fin;
   logic [63:0] mq;     // rounded product magnitude
   logic [63:0] mag;    // magnitude to sign and clamp
   logic [31:0] res_in;
   status_type  st_in;

   always_comb begin
      fin    = carry_ff[NW+1];
      mq     = (fin.prod + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      mag    = (fin.action == ACT_MUL) ? mq : 64'(quo_w[NW]);
      res_in = fin.res;
      st_in  = fin.status;
      if (fin.action == ACT_MUL || fin.action == ACT_DIV) begin
         if (fin.action == ACT_DIV && fin.dz) begin
            res_in = '0;
            st_in  = ST_DIV0;
         end else if (fin.neg) begin
            // a negative result reaches down to -2^31
            if (mag > 64'h8000_0000) begin
               res_in = SAT_MIN;
               st_in  = ST_OVF;
            end else begin
               res_in = 32'(-mag);
               st_in  = ST_OK;
            end
         end else begin
            if (mag > 64'h7FFF_FFFF) begin
               res_in = SAT_MAX;
               st_in  = ST_OVF;
            end else begin
               res_in = mag[31:0];
               st_in  = ST_OK;
            end
         end
      end
   end

   logic [31:0] res_ff;
   logic        cmp_ff;
   status_type  st_ff;

   always_ff @(posedge clock) begin
      if (en[NS-1]) begin
         res_ff <= res_in;
         cmp_ff <= fin.cmp;
         st_ff  <= st_in;
      end
   end

   assign rsp_tvalid = v_ff[NS-1];
   assign rsp_tdata  = {5'd0, st_ff, cmp_ff, res_ff};

endmodule

// ----- design/fpa_div_stage.sv -----
// one restoring-division step with its registers
// depends on nothing but its parameter
`timescale 1ns / 1ps

module fpa_div_stage #(
   parameter int unsigned NW = 41
) (
   input  logic          clock,
   input  logic          en,
   input  logic [32:0]   rem_i,
   input  logic [NW-1:0] quo_i,
   input  logic [32:0]   d_i,
   output logic [32:0]   rem_ff,
   output logic [NW-1:0] quo_ff,
   output logic [32:0]   d_ff
);

   logic [33:0]   t;
   logic [33:0]   diff;
   logic          ge;
   logic [32:0]   rem_in;
   logic [NW-1:0] quo_in;

   always_comb begin
      t      = {rem_i, quo_i[NW-1]};
      diff   = t - {1'b0, d_i};
      ge     = (t >= {1'b0, d_i});
      rem_in = ge ? diff[32:0] : t[32:0];
      quo_in = {quo_i[NW-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         d_ff   <= d_i;
      end
   end

endmodule

// ----- design/fpa_checker.sv -----
// port-level checks for the fixed-point alu, bound to the top level
// depends on fpa_pkg and fixed_point_alu_q24_8
`timescale 1ns / 1ps

module fpa_props
   import fpa_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);

   // a stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // nothing comes out right after reset
   a_rst: assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("result right after reset");

   // a true comparison carries zero value and ok status
   a_cmp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[32] |-> rsp_tdata[34:0] == 35'h1_0000_0000)
      else $error("comparison with nonzero value or status");

   // divide by zero yields zero, and no unused status code appears
   a_dz: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[34:33] != 2'd3 &&
                     (rsp_tdata[34:33] != ST_DIV0 || rsp_tdata[31:0] == '0))
      else $error("bad status or divide-by-zero value");

endmodule

bind fixed_point_alu_q24_8 fpa_props u_fpa_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
